// ===== design/mwo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mwo_pkg;

   // sizes fixed by the field widths
   localparam int PHASE_BITS        = 32;
   localparam int SINE_TABLE_BITS   = 10;
   localparam int SAMPLE_BITS       = 16;
   localparam int QUARTER_LEN       = (1 << SINE_TABLE_BITS) + 1;
   localparam int QUARTER_ADDR_BITS = SINE_TABLE_BITS + 1;
   localparam int RATE_BITS         = 18;
   localparam int PW_BITS           = 16;

   // serial divider: 48-bit dividend, 18-bit divisor, two quotient bits a cycle
   localparam int DIV_DIVIDEND_BITS = 48;
   localparam int DIV_DIVISOR_BITS  = 18;
   localparam int DIV_STEPS         = DIV_DIVIDEND_BITS / 2;
   localparam int DIV_COUNT_BITS    = $clog2(DIV_STEPS);

   // register map
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RATE_ADDR = 2'd0;
   localparam logic [RATE_BITS-1:0]     RATE_RESET    = 18'd48000;

   // waveform codes
   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SAW      = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_PULSE    = 2'd3
   } wave_type;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   typedef logic [SAMPLE_BITS-1:0] quarter_table_type [0:QUARTER_LEN-1];

   // quarter-wave sine, Q30 Taylor series, scaled to the sample grid
   function automatic quarter_table_type build_quarter();
      quarter_table_type tbl;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint unsigned   t;
      longint unsigned   v;
      longint            sum;
      for (int k = 0; k < QUARTER_LEN; k++) begin
         x    = (PI_HALF_Q30 * longint'(k)) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            t = (term * x2) >> 30;
            unique case (n)
               1:       term = t / 64'd6;
               2:       term = t / 64'd20;
               3:       term = t / 64'd42;
               4:       term = t / 64'd72;
               5:       term = t / 64'd110;
               default: term = t / 64'd156;
            endcase
            if ((n % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         v = ((longint'(sum) << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
         if (v > ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1))
            v = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
         tbl[k] = v[SAMPLE_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam quarter_table_type SINE_QUARTER = build_quarter();

endpackage
`default_nettype wire

// ===== design/mwo_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// request channel: one sample slot
interface mwo_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [31:0]              freq;
   logic                            gate;
   logic [1:0]                      waveform;
   logic [mwo_pkg::PW_BITS-1:0]     pulse_width;
   modport source (output valid, freq, gate, waveform, pulse_width, input ready);
   modport sink   (input valid, freq, gate, waveform, pulse_width, output ready);
endinterface

// response channel: one audio sample
interface mwo_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample;
   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface
`default_nettype wire

// ===== design/mwo_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, two quotient bits per cycle
module mwo_div (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic [mwo_pkg::DIV_DIVIDEND_BITS-1:0]   dividend,
   input  wire logic [mwo_pkg::DIV_DIVISOR_BITS-1:0]    divisor,
   output logic [mwo_pkg::DIV_DIVIDEND_BITS-1:0]        quotient,
   output logic                                         busy,
   output logic                                         done
);
   localparam int NB = mwo_pkg::DIV_DIVIDEND_BITS;
   localparam int DB = mwo_pkg::DIV_DIVISOR_BITS;
   localparam int CB = mwo_pkg::DIV_COUNT_BITS;

   logic [DB-1:0] rem_ff, rem_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [DB-1:0] den_ff;
   logic [CB-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [DB:0]   r1, r2;
   logic          ge1, ge2;
   logic [DB-1:0] r1s, r2s;
   logic [NB-1:0] q1, q2;

   // two dependent shift-subtract steps
   always_comb begin
      r1  = {rem_ff, quo_ff[NB-1]};
      ge1 = (r1 >= {1'b0, den_ff});
      r1s = ge1 ? DB'(r1 - {1'b0, den_ff}) : r1[DB-1:0];
      q1  = {quo_ff[NB-2:0], ge1};
      r2  = {r1s, q1[NB-1]};
      ge2 = (r2 >= {1'b0, den_ff});
      r2s = ge2 ? DB'(r2 - {1'b0, den_ff}) : r2[DB-1:0];
      q2  = {q1[NB-2:0], ge2};
   end

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = r2s;
         quo_in   = q2;
         count_in = count_ff + 1'b1;
         if (count_ff == CB'(mwo_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) den_ff <= divisor;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

// ===== design/mwo_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// quarter-wave sine table, registered read
module mwo_sine_rom (
   input  wire logic                                  clock,
   input  wire logic [mwo_pkg::QUARTER_ADDR_BITS-1:0] addr,
   output logic [mwo_pkg::SAMPLE_BITS-1:0]            data
);
   logic [mwo_pkg::SAMPLE_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= mwo_pkg::SINE_QUARTER[addr];
   end

   assign data = data_ff;
endmodule
`default_nettype wire

// ===== design/multi_waveform_oscillator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake          payload
// req      in   valid/ready        freq, gate, waveform, pulse_width
// rsp      out  valid/ready        sample
// csr      in   APB write/read     sample_rate at byte 0
//
// An item with gate clear passes from transfer to result through the two
// serial dividers (phase step and pulse level side by side, two bits a
// cycle over a 48-bit dividend, phase updated as they finish), the sine
// table read and a step to form the sample. A gated item yields no sample.
// Reset is synchronous; phase clears to zero, sample_rate returns to 48000.
// A waiting sample stalls the next item only at its last step.
module multi_waveform_oscillator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mwo_req_if.sink                                 req,
   mwo_rsp_if.source                               rsp,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mwo_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);
   localparam int PB = mwo_pkg::PHASE_BITS;
   localparam int SB = mwo_pkg::SAMPLE_BITS;
   localparam int RB = mwo_pkg::RATE_BITS;
   localparam int NB = mwo_pkg::DIV_DIVIDEND_BITS;
   localparam int DB = mwo_pkg::DIV_DIVISOR_BITS;
   localparam int TB = mwo_pkg::SINE_TABLE_BITS;
   localparam int AB = mwo_pkg::QUARTER_ADDR_BITS;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROM, S_SHAPE} state_type;

   state_type         state_ff, state_in;
   logic [RB-1:0]     rate_ff;
   logic [PB-1:0]     phase_ff, phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]     sample_ff, sample_in;
   logic              neg_ff;
   mwo_pkg::wave_type wave_ff;
   logic [16:0]       m_ff;

   // configuration
   logic csr_write;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == mwo_pkg::CSR_RATE_ADDR) ? {14'd0, rate_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= mwo_pkg::RATE_RESET;
      end else if (csr_write && csr_paddr == mwo_pkg::CSR_RATE_ADDR) begin
         rate_ff <= csr_pwdata[RB-1:0];
      end
   end

   // operands at transfer
   logic        accept, run;
   logic [31:0] mag;
   logic [16:0] m_req;
   logic        small_req;
   logic [16:0] hi_part;
   logic [16:0] den_req;
   logic [NB-1:0] ph_dividend, pl_dividend;
   logic [DB-1:0] ph_divisor, pl_divisor;

   assign accept = req.valid & req.ready;
   assign run    = accept & ~req.gate;

   always_comb begin
      mag         = req.freq[31] ? 32'(-req.freq) : 32'(req.freq);
      ph_dividend = {mag, 16'd0};
      ph_divisor  = (rate_ff == '0) ? DB'(1) : DB'(rate_ff);
      m_req       = (req.pulse_width == 16'hFFFF) ? 17'h10000 : {1'b0, req.pulse_width};
      small_req   = (m_req < 17'h08000);
      // numerator weight and denominator of the pulse level ratio
      hi_part     = small_req ? m_req : 17'(17'h10000 - m_req);
      den_req     = small_req ? 17'(17'h10000 - m_req) : m_req;
      pl_dividend = NB'({hi_part, 16'd0}) + NB'(den_req);
      pl_divisor  = {den_req, 1'b0};
   end

   // dividers
   logic [NB-1:0] ph_quo, pl_quo;
   logic          ph_busy, ph_done, pl_busy, pl_done;

   mwo_div u_ph_div (
      .clock(clock), .reset(reset), .start(run),
      .dividend(ph_dividend), .divisor(ph_divisor),
      .quotient(ph_quo), .busy(ph_busy), .done(ph_done)
   );

   mwo_div u_pl_div (
      .clock(clock), .reset(reset), .start(run),
      .dividend(pl_dividend), .divisor(pl_divisor),
      .quotient(pl_quo), .busy(pl_busy), .done(pl_done)
   );

   // sine table address from quadrant and fraction
   logic [AB-1:0] rom_addr;
   logic [SB-1:0] rom_data;
   always_comb begin
      if (phase_ff[PB-1-1])
         rom_addr = AB'((1 << TB)) - AB'(phase_ff[PB-3 -: TB]);
      else
         rom_addr = AB'(phase_ff[PB-3 -: TB]);
   end

   mwo_sine_rom u_rom (.clock(clock), .addr(rom_addr), .data(rom_data));

   // waveform shaping
   localparam logic signed [SB+1:0] F_POS  = (SB+2)'(1 << (SB-1));
   localparam logic signed [SB+1:0] MAX_V  = (SB+2)'((1 << (SB-1)) - 1);
   localparam logic signed [SB+1:0] MIN_V  = -F_POS;

   logic signed [SB+1:0] level;
   logic signed [SB+1:0] q4, pq;
   logic                 high;
   always_comb begin
      q4   = (SB+2)'(phase_ff[PB-1 -: SB+1]);
      pq   = (SB+2)'(pl_quo[16:0]);
      high = ({1'b0, phase_ff[PB-1 -: 16]} < m_ff);
      unique case (wave_ff)
         mwo_pkg::WAVE_SINE:
            level = phase_ff[PB-1] ? -(SB+2)'(rom_data) : (SB+2)'(rom_data);
         mwo_pkg::WAVE_SAW:
            level = F_POS - (SB+2)'(phase_ff[PB-1 -: SB]);
         mwo_pkg::WAVE_TRIANGLE: begin
            if (q4 < F_POS)            level = q4;
            else if (q4 < 3 * F_POS)   level = (SB+2)'(2 * F_POS - q4);
            else                       level = (SB+2)'(q4 - 4 * F_POS);
         end
         mwo_pkg::WAVE_PULSE: begin
            if (m_ff < 17'h08000) level = high ? F_POS : -pq;
            else                  level = high ? pq : -F_POS;
         end
         default: level = '0;
      endcase
      if (level > MAX_V)      sample_in = SB'(MAX_V);
      else if (level < MIN_V) sample_in = SB'(MIN_V);
      else                    sample_in = SB'(level);
   end

   // sequencer
   logic load;
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      load         = 1'b0;
      unique case (state_ff)
         S_IDLE:  if (run) state_in = S_DIV;
         S_DIV: begin
            if (ph_done) begin
               phase_in = neg_ff ? phase_ff - ph_quo[PB-1:0] : phase_ff + ph_quo[PB-1:0];
               state_in = S_ROM;
            end
         end
         S_ROM:   state_in = S_SHAPE;
         S_SHAPE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (load)                        rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      else                             rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) sample_ff <= sample_in;
      end
   end

   // item fields kept for the phase update and the shaping step
   always_ff @(posedge clock) begin
      if (run) begin
         neg_ff  <= req.freq[31];
         wave_ff <= mwo_pkg::wave_type'(req.waveform);
         m_ff    <= m_req;
      end
   end

   assign req.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.sample = sample_ff;

`ifndef SYNTHESIS
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ph_busy && !pl_busy)
      else $error("divider busy while idle");
   a_run_div: assert property (@(posedge clock) disable iff (reset)
      run |=> state_ff == S_DIV && ph_busy && pl_busy)
      else $error("transfer did not start division");
   a_div_pair: assert property (@(posedge clock) disable iff (reset)
      ph_done == pl_done)
      else $error("dividers out of step");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_SHAPE)
      else $error("result without shaping step");
`endif
endmodule
`default_nettype wire

// ===== tb/multi_waveform_oscillator_tb.sv =====
`timescale 1ns / 1ps
// scoreboard: holds predicted samples and the oscillator's own phase copy
class osc_scoreboard;
   logic [31:0]                           phase_acc;
   logic [17:0]                           rate;
   logic signed [mwo_pkg::SAMPLE_BITS-1:0] pending[$];
   longint                                quarter[0:mwo_pkg::QUARTER_LEN-1];
   int                                    errors;

   function new();
      phase_acc = 0;
      rate      = 18'd48000;
      errors    = 0;
      make_quarter();
   endfunction

   // quarter-wave sine, Q30 Taylor series of six terms past x
   function void make_quarter();
      longint unsigned x, x2, term, v;
      longint          sum;
      for (int k = 0; k < mwo_pkg::QUARTER_LEN; k++) begin
         x    = (64'd1686629713 * longint'(k)) >> mwo_pkg::SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2) sum -= longint'(term);
            else       sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
         quarter[k] = (v > 32767) ? 32767 : longint'(v);
      end
   endfunction

   function longint pulse_level(logic [31:0] p, logic [15:0] pw);
      longint unsigned m, num, den;
      bit              high;
      m    = (pw == 16'hFFFF) ? 65536 : pw;
      high = longint'(p) < (m << 16);
      if (m < 32768) begin
         if (high) return 32768;
         num = m * 32768;
         den = 65536 - m;
         return -longint'((2 * num + den) / (2 * den));
      end
      if (!high) return -32768;
      num = (65536 - m) * 32768;
      den = m;
      return longint'((2 * num + den) / (2 * den));
   endfunction

   // one accepted slot: unless gated, advance the phase and predict the sample
   function void note_slot(logic signed [31:0] freq, logic gate, mwo_pkg::wave_type wave,
                           logic [15:0] pw);
      longint unsigned mag, sr, inc;
      longint          v, q4;
      logic [9:0]      idx;
      logic [10:0]     ti;
      if (gate) return;
      sr  = (rate == 0) ? 1 : rate;
      mag = freq[31] ? (64'h1_0000_0000 - longint'(unsigned'(freq)))
                     : longint'(unsigned'(freq));
      inc = ((mag / sr) << 16) + (((mag % sr) << 16) / sr);
      if (freq[31]) phase_acc = phase_acc - inc[31:0];
      else          phase_acc = phase_acc + inc[31:0];
      case (wave)
         mwo_pkg::WAVE_SINE: begin
            idx = phase_acc[29:20];
            ti  = phase_acc[30] ? (11'd1024 - idx) : {1'b0, idx};
            v   = phase_acc[31] ? -quarter[ti] : quarter[ti];
         end
         mwo_pkg::WAVE_SAW: v = 32768 - longint'(phase_acc[31:16]);
         mwo_pkg::WAVE_TRIANGLE: begin
            q4 = longint'(phase_acc[31:15]);
            if (q4 < 32768)      v = q4;
            else if (q4 < 98304) v = 65536 - q4;
            else                 v = q4 - 131072;
         end
         default: v = pulse_level(phase_acc, pw);
      endcase
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      pending.push_back(v[15:0]);
   endfunction

   function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected sample, expected none, actual %0d", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module multi_waveform_oscillator_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [1:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          send_idle, take_idle;
   osc_scoreboard board;

   mwo_req_if req ();
   mwo_rsp_if rsp ();

   multi_waveform_oscillator dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req.valid = 0; req.freq = 0; req.gate = 0; req.waveform = 0; req.pulse_width = 0;
      rsp.ready = 0;
   end

   // receiver: random stall, check every transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) board.check_sample(rsp.sample);
         rsp.ready <= ($urandom_range(99) >= take_idle);
      end
   end

   // valid stays up after a transfer until the next slot or an idle cycle
   task automatic send_slot(logic signed [31:0] f, logic g, logic [1:0] w, logic [15:0] pw);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid       <= 1;
      req.freq        <= f;
      req.gate        <= g;
      req.waveform    <= w;
      req.pulse_width <= pw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_slot(f, g, mwo_pkg::wave_type'(w), pw);
   endtask

   // wait out outstanding results, then the pipeline latency
   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] addr, logic [31:0] data);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (addr == mwo_pkg::CSR_RATE_ADDR) board.rate = data[17:0];
   endtask

   task automatic random_slot();
      logic signed [31:0] f;
      logic [15:0]        pw;
      case ($urandom_range(3))
         0:       f = $urandom;
         1:       f = $signed($urandom_range(20000 << 16)) - (10000 << 16);
         default: f = $signed($urandom_range(4000 << 16));
      endcase
      case ($urandom_range(4))
         0:       pw = 0;
         1:       pw = 16'hFFFF;
         2:       pw = 16'(16'h8000 + $urandom_range(1) - 1);
         default: pw = 16'($urandom);
      endcase
      send_slot(f, ($urandom_range(9) == 0), 2'($urandom_range(3)), pw);
   endtask

   task automatic phase_run(int count);
      for (int i = 0; i < count; i++) random_slot();
      drain();
   endtask

   initial begin
      board = new();
      send_idle = 34;
      take_idle = 76;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes of every field, each waveform, zero and full widths
      send_slot(32'sh7FFF_FFFF, 0, mwo_pkg::WAVE_SINE, 0);
      send_slot(32'sh8000_0000, 0, mwo_pkg::WAVE_SAW, 0);
      send_slot(0, 0, mwo_pkg::WAVE_TRIANGLE, 0);
      send_slot(32'sh0001_0000, 1, mwo_pkg::WAVE_PULSE, 16'hFFFF);
      send_slot(32'sh03E8_0000, 0, mwo_pkg::WAVE_PULSE, 0);
      send_slot(32'sh03E8_0000, 0, mwo_pkg::WAVE_PULSE, 16'hFFFF);
      send_slot(32'sh03E8_0000, 0, mwo_pkg::WAVE_PULSE, 16'h7FFF);
      send_slot(32'sh03E8_0000, 0, mwo_pkg::WAVE_PULSE, 16'h8000);
      send_slot(-32'sh2EE0_0000, 0, mwo_pkg::WAVE_SINE, 16'h5555);
      send_slot(32'sh2EE0_0000, 0, mwo_pkg::WAVE_TRIANGLE, 16'hAAAA);
      send_slot(32'sh0BB8_0000, 0, mwo_pkg::WAVE_SAW, 16'h1234);
      send_slot(32'sh0000_0001, 0, mwo_pkg::WAVE_PULSE, 16'h0001);
      drain();

      // zero sample rate, extremes, unknown register
      csr_write(mwo_pkg::CSR_RATE_ADDR, 0);
      send_slot(32'sh0000_8000, 0, mwo_pkg::WAVE_SAW, 0);
      send_slot(32'sh7FFF_FFFF, 0, mwo_pkg::WAVE_SINE, 0);
      drain();
      csr_write(2'd1, 32'hFFFF_FFFF);
      csr_write(2'd3, 32'h0000_1234);
      csr_write(mwo_pkg::CSR_RATE_ADDR, 32'hFFFF_FFFF);
      phase_run(100);
      csr_write(mwo_pkg::CSR_RATE_ADDR, 8000);
      phase_run(300);
      csr_write(mwo_pkg::CSR_RATE_ADDR, 192000);
      phase_run(200);

      send_idle = 76;
      take_idle = 34;
      csr_write(mwo_pkg::CSR_RATE_ADDR, 44100);
      phase_run(450);

      send_idle = 0;
      take_idle = 0;
      csr_write(mwo_pkg::CSR_RATE_ADDR, 48000);
      phase_run(450);

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("[multi_waveform_oscillator] OK");
      end else begin
         $display("[multi_waveform_oscillator] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[multi_waveform_oscillator] ERROR");
      $finish;
   end
endmodule
